FILE: hw/rtl/ttip_pkg.sv
// Shared types and constants of the text-to-integer parser.
package ttip_pkg;

  localparam int CHAR_W  = 8;
  localparam int BASE_W  = 6;
  localparam int VAL_W   = 64;
  localparam int LEN_W   = 13;
  localparam int DIGIT_W = 6;

  localparam logic [BASE_W-1:0]  BASE_RESET   = 6'd10;
  localparam logic [BASE_W-1:0]  BASE_AUTO    = 6'd0;
  localparam logic [BASE_W-1:0]  BASE_UNARY   = 6'd1;
  localparam logic [BASE_W-1:0]  BASE_MAX     = 6'd36;
  localparam logic [BASE_W-1:0]  BASE_OCT     = 6'd8;
  localparam logic [BASE_W-1:0]  BASE_DEC     = 6'd10;
  localparam logic [BASE_W-1:0]  BASE_HEX     = 6'd16;
  // digit code of a byte that is no digit at all; above every legal base
  localparam logic [DIGIT_W-1:0] DIGIT_NONE   = 6'd63;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;

  // one classified character, front to back
  typedef struct packed {
    logic               start;
    logic               is_space;
    logic               is_minus;
    logic               is_plus;
    logic               is_zero;
    logic               is_x;
    logic [DIGIT_W-1:0] digit;
  } item_t;

  // one parse result
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [LEN_W-1:0] length;
  } result_t;

endpackage

FILE: hw/rtl/ttip_fifo.sv
// Small show-ahead queue built from registers.
module ttip_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_rd) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_wr && !do_rd) cnt_r <= cnt_r + CNT_W'(1);
      else if (do_rd && !do_wr) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

FILE: hw/rtl/ttip_front.sv
// Front end: classifies each input byte for the parse engine.
module ttip_front import ttip_pkg::*; (
  input  logic [CHAR_W-1:0] character,
  input  logic              string_start,
  output item_t             item
);

  logic [CHAR_W-1:0]  c;
  logic [DIGIT_W-1:0] digit;
  assign c = character;

  // digit value 0..35, or none
  always_comb begin
    if (c >= CH_ZERO && c <= CH_NINE)
      digit = DIGIT_W'(c - CH_ZERO);
    else if (c >= CH_LOW_A && c <= CH_LOW_Z)
      digit = DIGIT_W'(c - CH_LOW_A + 8'd10);
    else if (c >= CH_UP_A && c <= CH_UP_Z)
      digit = DIGIT_W'(c - CH_UP_A + 8'd10);
    else
      digit = DIGIT_NONE;
  end

  // character classes
  assign item.digit    = digit;
  assign item.start    = string_start;
  assign item.is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign item.is_minus = (c == CH_MINUS);
  assign item.is_plus  = (c == CH_PLUS);
  assign item.is_zero  = (c == CH_ZERO);
  assign item.is_x     = (c == CH_LOW_X) || (c == CH_UP_X);

endmodule

FILE: hw/rtl/ttip_back.sv
// Back end: parse state machine with the multiply-add accumulator.
module ttip_back import ttip_pkg::*; #(
  parameter int MAX_TEXT_LENGTH = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BASE_W-1:0] number_base,
  input  logic              item_valid,
  input  item_t             item,
  output logic              item_take,
  input  logic              res_full,
  output logic              res_push,
  output result_t           res
);

  localparam int CNT_W = $clog2(MAX_TEXT_LENGTH + 1);

  typedef enum logic [2:0] {
    PH_SPACE, PH_START, PH_ZERO, PH_HEXPFX, PH_DIGITS, PH_DONE
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [BASE_W-1:0]  base_r, base_nxt;
  logic [VAL_W-1:0]   mag_r, mag_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  phase_t             ph;
  logic               neg;
  logic [BASE_W-1:0]  base;
  logic [VAL_W-1:0]   mag;
  logic [CNT_W-1:0]   cnt;
  logic [VAL_W-1:0]   mac;
  logic [CNT_W:0]     sum1, sum2;
  logic [CNT_W-1:0]   cnt_p1, cnt_p2;
  logic               emit, any_digit;
  logic [VAL_W-1:0]   val_out;
  logic [LEN_W+CNT_W-1:0] len_ext;

  // take a beat whenever the result queue has room
  assign item_take = item_valid && !res_full;

  // a start mark clears the parser before the byte is handled
  assign ph   = item.start ? PH_SPACE : phase_r;
  assign neg  = item.start ? 1'b0 : neg_r;
  assign base = item.start ? '0 : base_r;
  assign mag  = item.start ? '0 : mag_r;
  assign cnt  = item.start ? '0 : cnt_r;

  // saturating length increments
  assign sum1   = {1'b0, cnt} + (CNT_W+1)'(1);
  assign sum2   = {1'b0, cnt} + (CNT_W+1)'(2);
  assign cnt_p1 = (sum1 > (CNT_W+1)'(MAX_TEXT_LENGTH)) ? CNT_W'(MAX_TEXT_LENGTH)
                                                       : sum1[CNT_W-1:0];
  assign cnt_p2 = (sum2 > (CNT_W+1)'(MAX_TEXT_LENGTH)) ? CNT_W'(MAX_TEXT_LENGTH)
                                                       : sum2[CNT_W-1:0];

  // next state per character
  always_comb begin
    logic [BASE_W-1:0] b;
    logic [BASE_W-1:0] ab;
    logic              first;
    logic              digits;
    phase_nxt = ph;
    neg_nxt   = neg;
    base_nxt  = base;
    mag_nxt   = mag;
    cnt_nxt   = cnt;
    emit      = 1'b0;
    any_digit = 1'b0;
    first     = 1'b0;
    digits    = 1'b0;
    b         = number_base;
    ab        = base;
    unique case (ph)
      PH_SPACE: begin
        if (item.is_space) begin
          cnt_nxt = cnt_p1;
        end else if (item.is_minus || item.is_plus) begin
          neg_nxt   = item.is_minus;
          cnt_nxt   = cnt_p1;
          phase_nxt = PH_START;
        end else begin
          first = 1'b1;
        end
      end
      PH_START: first = 1'b1;
      PH_ZERO: begin
        if (item.is_x) begin
          base_nxt  = BASE_HEX;
          phase_nxt = PH_HEXPFX;
        end else begin
          phase_nxt = PH_DIGITS;
          digits    = 1'b1;
        end
      end
      PH_DIGITS: digits = 1'b1;
      PH_HEXPFX: begin
        if (item.digit >= BASE_HEX) begin
          emit      = 1'b1;
          any_digit = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          mag_nxt   = VAL_W'(item.digit);
          cnt_nxt   = cnt_p2;
          phase_nxt = PH_DIGITS;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    // first byte after whitespace and sign: fix the radix
    if (first) begin
      if (b == BASE_UNARY || b > BASE_MAX) begin
        emit      = 1'b1;
        phase_nxt = PH_DONE;
      end else if (item.is_zero && (b == BASE_AUTO || b == BASE_HEX)) begin
        base_nxt  = (b == BASE_AUTO) ? BASE_OCT : BASE_HEX;
        cnt_nxt   = cnt_p1;
        phase_nxt = PH_ZERO;
      end else begin
        ab       = (b == BASE_AUTO) ? BASE_DEC : b;
        base_nxt = ab;
        if (item.digit >= ab) begin
          emit      = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          mag_nxt   = VAL_W'(item.digit);
          cnt_nxt   = cnt_p1;
          phase_nxt = PH_DIGITS;
        end
      end
    end

    // ordinary digit: multiply-add or finish
    if (digits) begin
      if (item.digit >= base) begin
        emit      = 1'b1;
        any_digit = 1'b1;
        phase_nxt = PH_DONE;
      end else begin
        mag_nxt = mac;
        cnt_nxt = cnt_p1;
      end
    end
  end

  assign mac = mag * VAL_W'(base) + VAL_W'(item.digit);

  // result formatting
  assign val_out    = neg ? (VAL_W'(0) - mag) : mag;
  assign len_ext    = {{LEN_W{1'b0}}, cnt};
  assign res.value  = any_digit ? val_out : '0;
  assign res.length = any_digit ? len_ext[LEN_W-1:0] : '0;
  assign res_push   = item_take && emit;

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
      neg_r   <= 1'b0;
      base_r  <= '0;
      mag_r   <= '0;
      cnt_r   <= '0;
    end else if (item_take) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      base_r  <= base_nxt;
      mag_r   <= mag_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/text_to_integer_parser.sv
// Top level of the streaming text-to-integer parser.
// Takes one text byte per beat and emits one result (value, consumed length)
// at the first byte that ends the number. Sustained rate is one byte per
// cycle while the result queue has room: the back end's parse state machine
// does one 64-bit by 6-bit multiply-add per byte, combinationally. A byte
// reaches the parse engine through a QUEUE_DEPTH-entry queue and its result
// leaves through another, so the byte and then its result are each registered
// in a queue before the result shows on the out_ ports. number_base is sampled
// at the first byte after whitespace and sign; reset sets it to 10.
module text_to_integer_parser import ttip_pkg::*; #(
  parameter int MAX_TEXT_LENGTH = 4096,
  parameter int QUEUE_DEPTH     = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_we,
  input  logic [BASE_W-1:0]       cfg_number_base,
  // input channel
  input  logic                    push,
  output logic                    full,
  input  logic [CHAR_W-1:0]       in_character,
  input  logic                    in_string_start,
  // result channel
  output logic                    empty,
  input  logic                    pop,
  output logic signed [VAL_W-1:0] out_parsed_value,
  output logic [LEN_W-1:0]        out_consumed_length
);

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(result_t);

  logic [BASE_W-1:0] base_r;
  item_t             in_item, q_item;
  logic [ITEM_W-1:0] q_data;
  logic              q_empty, q_take;
  result_t           res, out_res;
  logic [RES_W-1:0]  out_data;
  logic              res_push, res_full;

  // radix register
  always_ff @(posedge clk) begin
    if (!rst_n) base_r <= BASE_RESET;
    else if (cfg_we) base_r <= cfg_number_base;
  end

  // classify incoming bytes
  ttip_front u_front (
    .character    (in_character),
    .string_start (in_string_start),
    .item         (in_item)
  );

  // queue between front and back
  ttip_fifo #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_item_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (in_item),
    .full    (full),
    .rd_en   (q_take),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  assign q_item = item_t'(q_data);

  // parse engine
  ttip_back #(.MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .number_base (base_r),
    .item_valid  (!q_empty),
    .item        (q_item),
    .item_take   (q_take),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res)
  );

  // result queue
  ttip_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

  assign out_res             = result_t'(out_data);
  assign out_parsed_value    = out_res.value;
  assign out_consumed_length = out_res.length;

endmodule

FILE: tb/text_to_integer_parser_tb.sv
// Self-checking testbench of the streaming text-to-integer parser.
module text_to_integer_parser_tb;
  import ttip_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN       = 4096;
  localparam int PHASE_BYTES   = 35;   // minimum random bytes queued per base setting
  localparam int SETTLE_CYCLES = 10;   // byte queue, parse stage and result queue
  localparam int HOLD_CYCLES   = 300;  // the one long receiver hold-off
  localparam int IDLE_LIMIT    = 3000; // cycles with no beat on either side

  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_VT  = 8'h0b;
  localparam logic [CHAR_W-1:0] CH_FF  = 8'h0c;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              start;
  } text_byte_t;

  typedef enum logic [2:0] {
    PH_WS, PH_LEAD, PH_ZERO, PH_PREFIX, PH_DIGITS, PH_DONE
  } parse_phase_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [BASE_W-1:0]       cfg_number_base = BASE_RESET;
  logic                    push = 1'b0;
  logic                    full;
  logic [CHAR_W-1:0]       in_character = '0;
  logic                    in_string_start = 1'b0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic signed [VAL_W-1:0] out_parsed_value;
  logic [LEN_W-1:0]        out_consumed_length;

  text_to_integer_parser #(.MAX_TEXT_LENGTH(MAX_LEN)) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_number_base     (cfg_number_base),
    .push                (push),
    .full                (full),
    .in_character        (in_character),
    .in_string_start     (in_string_start),
    .empty               (empty),
    .pop                 (pop),
    .out_parsed_value    (out_parsed_value),
    .out_consumed_length (out_consumed_length)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // bytes waiting to be sent and parse results waiting to come out
  text_byte_t text_bytes[$];
  result_t    expected_results[$];
  int         bytes_queued = 0;
  bit         text_head = 1'b0;
  bit         force_fresh = 1'b0;
  int         errors = 0;
  int         results_seen = 0;

  // parser state as the block should hold it
  logic [BASE_W-1:0] base_reg = BASE_RESET;
  parse_phase_t      ps_phase = PH_WS;
  bit                ps_neg = 1'b0;
  int                ps_radix = 0;
  logic [VAL_W-1:0]  ps_mag = '0;
  int                ps_count = 0;

  function automatic int digit_value(input logic [CHAR_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LOW_A && c <= CH_LOW_Z) return int'(c - CH_LOW_A) + 10;
    if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c - CH_UP_A) + 10;
    return 255;
  endfunction

  function automatic bit is_blank(input logic [CHAR_W-1:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic void bump_count(input int n);
    ps_count = (ps_count + n > MAX_LEN) ? MAX_LEN : ps_count + n;
  endfunction

  function automatic void finish_number(output result_t res);
    res.value  = ps_neg ? (64'd0 - ps_mag) : ps_mag;
    res.length = LEN_W'(ps_count);
    ps_phase   = PH_DONE;
  endfunction

  // Advance the parser by one byte; returns 1 when the byte ends the number.
  // Phases are tested in order so that a byte can fall into the next one.
  function automatic bit parse_step(input logic [CHAR_W-1:0] c, input logic fresh,
                                    output result_t res);
    int d;
    res = '0;
    if (fresh) begin
      ps_phase = PH_WS;
      ps_neg   = 1'b0;
      ps_radix = 0;
      ps_mag   = '0;
      ps_count = 0;
    end
    if (ps_phase == PH_WS) begin
      if (is_blank(c)) begin
        bump_count(1);
        return 1'b0;
      end
      if (c == CH_MINUS || c == CH_PLUS) begin
        ps_neg = (c == CH_MINUS);
        bump_count(1);
        ps_phase = PH_LEAD;
        return 1'b0;
      end
      ps_phase = PH_LEAD;
    end
    if (ps_phase == PH_LEAD) begin
      // base sampled here; an illegal base takes no digit
      if (base_reg == BASE_UNARY || base_reg > BASE_MAX) begin
        ps_phase = PH_DONE;
        return 1'b1;
      end
      if (c == CH_ZERO && (base_reg == BASE_AUTO || base_reg == BASE_HEX)) begin
        ps_radix = (base_reg == BASE_AUTO) ? 8 : 16;
        bump_count(1);
        ps_phase = PH_ZERO;
        return 1'b0;
      end
      ps_radix = (base_reg == BASE_AUTO) ? 10 : int'(base_reg);
      d = digit_value(c);
      if (d >= ps_radix) begin
        ps_phase = PH_DONE;
        return 1'b1;
      end
      ps_mag = VAL_W'(d);
      bump_count(1);
      ps_phase = PH_DIGITS;
      return 1'b0;
    end
    if (ps_phase == PH_ZERO) begin
      // the x is only counted once a hex digit follows it
      if (c == CH_LOW_X || c == CH_UP_X) begin
        ps_radix = 16;
        ps_phase = PH_PREFIX;
        return 1'b0;
      end
      ps_phase = PH_DIGITS;
    end
    if (ps_phase == PH_DIGITS) begin
      d = digit_value(c);
      if (d >= ps_radix) begin
        finish_number(res);
        return 1'b1;
      end
      ps_mag = ps_mag * VAL_W'(ps_radix) + VAL_W'(d);
      bump_count(1);
      return 1'b0;
    end
    if (ps_phase == PH_PREFIX) begin
      d = digit_value(c);
      if (d >= 16) begin
        finish_number(res);
        return 1'b1;
      end
      ps_mag = VAL_W'(d);
      bump_count(2);
      ps_phase = PH_DIGITS;
      return 1'b0;
    end
    return 1'b0;
  endfunction

  // gap length: mostly none or short, a few long, none at all in a burst
  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------- stimulus helpers ----------------
  task automatic begin_text(input bit fresh);
    text_head   = fresh || force_fresh;
    force_fresh = 1'b0;
  endtask

  task automatic put_byte(input logic [CHAR_W-1:0] c);
    text_bytes.push_back('{chr: c, start: text_head});
    text_head = 1'b0;
    bytes_queued++;
  endtask

  task automatic add_bytes(input string body, input bit fresh);
    begin_text(fresh);
    for (int i = 0; i < body.len(); i++) put_byte(body[i]);
  endtask

  task automatic add_text(input string body, input logic [CHAR_W-1:0] ending,
                          input bit fresh);
    add_bytes(body, fresh);
    put_byte(ending);
  endtask

  function automatic logic [CHAR_W-1:0] blank_char();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] x_char();
    return $urandom_range(0, 1) ? CH_LOW_X : CH_UP_X;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input int v);
    if (v < 10) return CH_ZERO + CHAR_W'(v);
    return ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + CHAR_W'(v - 10);
  endfunction

  // One random text for base b: mostly well formed, some pure noise,
  // a few cut short and restarted by the next text.
  task automatic add_random_text(input logic [BASE_W-1:0] b);
    int  radix;
    int  n;
    int  v;
    int  r;
    bit  dec_auto;
    bit  cut;
    cut = ($urandom_range(0, 11) == 0);
    begin_text($urandom_range(0, 19) != 0);
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 8)) put_byte(CHAR_W'($urandom_range(0, 255)));
      put_byte(CH_NUL);
      return;
    end
    repeat ($urandom_range(0, 3)) put_byte(blank_char());
    r = $urandom_range(0, 3);
    if (r == 1) put_byte(CH_MINUS);
    else if (r == 2) put_byte(CH_PLUS);
    radix    = (b == BASE_UNARY || b > BASE_MAX) ? 36 : int'(b);
    dec_auto = 1'b0;
    if (b == BASE_AUTO) begin
      r = $urandom_range(0, 2);
      if (r == 0) begin
        put_byte(CH_ZERO);
        put_byte(x_char());
        radix = 16;
      end else if (r == 1) begin
        put_byte(CH_ZERO);
        radix = 8;
      end else begin
        radix    = 10;
        dec_auto = 1'b1;
      end
    end else if (b == BASE_HEX && $urandom_range(0, 1)) begin
      put_byte(CH_ZERO);
      put_byte(x_char());
    end
    r = $urandom_range(0, 9);
    n = (r == 0) ? 0 : (r < 8) ? $urandom_range(1, 8) : $urandom_range(10, 30);
    for (int i = 0; i < n; i++) begin
      v = (dec_auto && i == 0) ? $urandom_range(1, 9) : $urandom_range(0, radix - 1);
      put_byte(digit_char(v));
    end
    if (cut) begin
      force_fresh = 1'b1;
      return;
    end
    if ($urandom_range(0, 1)) put_byte(CHAR_W'($urandom_range(0, 255)));
    put_byte(CH_NUL);
  endtask

  // wait until every byte is in and every result out, then let the pipe drain
  task automatic settle();
    while (text_bytes.size() != 0 || push || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] b);
    @(posedge clk);
    cfg_we          <= 1'b1;
    cfg_number_base <= b;
    base_reg         = b;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------- driver ----------------
  text_byte_t tx_item;
  result_t    tx_res;
  bit         tx_taken;
  bit         tx_burst = 1'b0;
  int         tx_wait = 0;
  int         tx_beats = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      tx_taken = push && !full;
      // predict on the accepted beat
      if (tx_taken) begin
        if (parse_step(tx_item.chr, tx_item.start, tx_res))
          expected_results.push_back(tx_res);
        tx_beats++;
        if (tx_beats % 50 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        tx_wait = pick_gap(tx_burst);
      end
      // a beat not yet taken stays on the ports
      if (!push || tx_taken) begin
        if (tx_wait > 0) begin
          tx_wait--;
          push <= 1'b0;
        end else if (text_bytes.size() != 0) begin
          tx_item = text_bytes.pop_front();
          push            <= 1'b1;
          in_character    <= tx_item.chr;
          in_string_start <= tx_item.start;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  result_t rx_exp;
  bit      rx_taken;
  bit      rx_burst = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_left = 0;
  int      rx_wait = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      rx_taken = pop && !empty;
      if (rx_taken) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: value %0d length %0d",
                   $time, out_parsed_value, out_consumed_length);
        end else begin
          rx_exp = expected_results.pop_front();
          if (out_parsed_value !== rx_exp.value) begin
            errors++;
            $display("%0t: parsed_value expected %0d, got %0d",
                     $time, $signed(rx_exp.value), out_parsed_value);
          end
          if (out_consumed_length !== rx_exp.length) begin
            errors++;
            $display("%0t: consumed_length expected %0d, got %0d",
                     $time, rx_exp.length, out_consumed_length);
          end
        end
        if (results_seen % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        rx_wait = pick_gap(rx_burst);
      end
      // one long hold-off while plenty of bytes are still to be sent
      if (!hold_done && results_seen >= 30 && text_bytes.size() > 30) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------- watchdog ----------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------- sequence ----------------
  logic [BASE_W-1:0] plan[$];
  int                phase_start;

  initial begin
    plan = '{BASE_AUTO, BASE_HEX, 6'd2, BASE_MAX, BASE_OCT, BASE_UNARY, 6'd37, 6'd63,
             BASE_DEC};
    plan.push_back(BASE_W'($urandom_range(0, 63)));
    plan.push_back(BASE_W'($urandom_range(0, 63)));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset base 10; the first text comes without a start flag
    add_text("42", CH_NUL, 1'b0);
    add_text("", CH_NUL, 1'b1);
    add_text(" \011\012\013\014\015", CH_NUL, 1'b1);
    add_text("-", CH_NUL, 1'b1);
    add_text("+", CH_SPACE, 1'b1);
    add_text("  -123abc", CH_NUL, 1'b1);
    add_text("9223372036854775807", CH_NUL, 1'b1);
    add_text("-9223372036854775808", CH_NUL, 1'b1);
    add_text("99999999999999999999999", 8'hff, 1'b1);
    add_text("00000000000000000000000000000000001", CH_MINUS, 1'b1);
    // text cut short, then a fresh one
    add_bytes("12", 1'b1);
    add_text("7", CH_NUL, 1'b1);
    settle();

    foreach (plan[p]) begin
      write_base(plan[p]);
      case (plan[p])
        BASE_AUTO: begin
          add_text("0x1F", CH_NUL, 1'b1);
          add_text("0X", CH_NUL, 1'b1);
          add_text("0xg", CH_NUL, 1'b1);
          add_text("017", CH_NUL, 1'b1);
          add_text("08", CH_NUL, 1'b1);
          add_text("0", CH_NUL, 1'b1);
          add_text("-0x8000000000000000", CH_NUL, 1'b1);
          add_text(" +0XffffFFFFffffFFFF", 8'h2e, 1'b1);
          add_text("z", CH_NUL, 1'b1);
        end
        BASE_HEX: begin
          add_text("0x", 8'h47, 1'b1);
          add_text("0xABCdef", CH_NUL, 1'b1);
          add_text("ff", CH_NUL, 1'b1);
          add_text("-0X7", CH_NUL, 1'b1);
          add_bytes("0x", 1'b1);
          add_text("1", CH_NUL, 1'b1);
        end
        BASE_MAX: add_text("zZ9", CH_NUL, 1'b1);
        6'd2:     add_text("1012", CH_NUL, 1'b1);
        default: ;
      endcase
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_BYTES) add_random_text(plan[p]);
      settle();
    end

    if (errors == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ttip_pkg.sv
hw/rtl/ttip_fifo.sv
hw/rtl/ttip_front.sv
hw/rtl/ttip_back.sv
hw/rtl/text_to_integer_parser.sv
tb/text_to_integer_parser_tb.sv
